>>> src/zzr_pkg.sv
// Shared constants and types for the zigzag row reorder block.
package zzr_pkg;

  localparam int unsigned MAX_LENGTH_DEF = 64;
  localparam int unsigned SYM_W          = 8;
  localparam int unsigned ROW_W          = 7;
  localparam int unsigned CYC_W          = 8;

  typedef struct packed {
    logic valid;
    logic last;
    logic flag;
  } rd_ctrl_t;

endpackage

>>> src/zzr_mem.sv
// Message buffer: one write port, one registered read port.
module zzr_mem #(
  parameter int unsigned MAX_LENGTH = zzr_pkg::MAX_LENGTH_DEF,
  localparam int unsigned ADDR_W    = $clog2(MAX_LENGTH)
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [ADDR_W-1:0]        waddr_i,
  input  logic [zzr_pkg::SYM_W-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [ADDR_W-1:0]        raddr_i,
  output logic [zzr_pkg::SYM_W-1:0] rdata_o
);

  logic [zzr_pkg::SYM_W-1:0] mem [MAX_LENGTH];
  logic [zzr_pkg::SYM_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/zzr_seq.sv
// Load counter and zigzag address sequencer around one shared position adder.
module zzr_seq #(
  parameter int unsigned MAX_LENGTH = zzr_pkg::MAX_LENGTH_DEF,
  localparam int unsigned ADDR_W    = $clog2(MAX_LENGTH)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      end_of_message_i,
  input  logic [zzr_pkg::ROW_W-1:0] row_count_i,
  output logic                      busy_o,
  output logic                      wr_en_o,
  output logic [ADDR_W-1:0]         wr_addr_o,
  output zzr_pkg::rd_ctrl_t         rd_o,
  output logic [ADDR_W-1:0]         rd_addr_o
);

  localparam int unsigned LEN_W = $clog2(MAX_LENGTH + 1);
  localparam int unsigned POS_W = $clog2(MAX_LENGTH + 2 ** zzr_pkg::CYC_W);
  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_LENGTH);

  typedef enum logic {
    IDLE,
    EMIT
  } state_e;

  state_e                      state_q;
  logic [LEN_W-1:0]            len_q;
  logic [LEN_W-1:0]            cnt_q;
  logic                        ovf_q;
  logic                        flag_q;
  logic                        ph_q;
  logic [zzr_pkg::ROW_W-1:0]   r_q;
  logic [zzr_pkg::ROW_W-1:0]   last_row_q;
  logic [zzr_pkg::CYC_W-1:0]   cyc_q;
  logic [POS_W-1:0]            base_q;

  logic                        accept;
  logic                        full;
  logic [zzr_pkg::ROW_W-1:0]   rows_eff;
  logic [zzr_pkg::CYC_W-1:0]   cyc_new;
  logic [POS_W-1:0]            off;
  logic [POS_W-1:0]            pos;
  logic                        hit;
  logic                        is_last;
  logic                        mid_row;

  assign accept   = start_i && (state_q == IDLE);
  assign full     = (len_q == MaxLen);
  assign rows_eff = (row_count_i == '0) ? zzr_pkg::ROW_W'(1) : row_count_i;
  assign cyc_new  = (rows_eff == zzr_pkg::ROW_W'(1)) ? zzr_pkg::CYC_W'(1)
                  : zzr_pkg::CYC_W'({rows_eff, 1'b0} - 8'd2);

  assign off     = ph_q ? (POS_W'(cyc_q) - POS_W'(r_q)) : POS_W'(r_q);
  assign pos     = base_q + off;
  assign hit     = (state_q == EMIT) && (pos < POS_W'(len_q));
  assign is_last = ((cnt_q + LEN_W'(1)) == len_q);
  assign mid_row = (r_q != '0) && (r_q != last_row_q);

  assign busy_o    = (state_q != IDLE);
  assign wr_en_o   = accept && !full;
  assign wr_addr_o = len_q[ADDR_W-1:0];
  assign rd_o      = '{valid: hit, last: is_last, flag: flag_q};
  assign rd_addr_o = pos[ADDR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= IDLE;
      len_q      <= '0;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      flag_q     <= 1'b0;
      ph_q       <= 1'b0;
      r_q        <= '0;
      last_row_q <= '0;
      cyc_q      <= '0;
      base_q     <= '0;
    end else begin
      case (state_q)
        IDLE: begin
          if (accept) begin
            if (!full) begin
              len_q <= len_q + LEN_W'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            if (end_of_message_i) begin
              state_q    <= EMIT;
              flag_q     <= ovf_q || full;
              cnt_q      <= '0;
              ph_q       <= 1'b0;
              r_q        <= '0;
              base_q     <= '0;
              cyc_q      <= cyc_new;
              last_row_q <= rows_eff - zzr_pkg::ROW_W'(1);
            end
          end
        end
        EMIT: begin
          if (hit) begin
            cnt_q <= cnt_q + LEN_W'(1);
          end
          if (hit && is_last) begin
            state_q <= IDLE;
            len_q   <= '0;
            ovf_q   <= 1'b0;
          end else if (ph_q) begin
            ph_q   <= 1'b0;
            base_q <= base_q + POS_W'(cyc_q);
          end else if (!hit) begin
            r_q    <= r_q + zzr_pkg::ROW_W'(1);
            base_q <= '0;
          end else if (mid_row) begin
            ph_q <= 1'b1;
          end else begin
            base_q <= base_q + POS_W'(cyc_q);
          end
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/zigzag_row_reorder.sv
// Top level of the zigzag row reorder block: config register, buffer, sequencer, output.
//
// Bytes load at one per cycle while busy_o is low. The word marked end_of_message
// starts the run: busy_o rises and the sequencer steps one candidate position per
// cycle through its shared position adder. Each word appears on out_symbol_o for
// exactly one cycle with strobe_o high, in the cycle after its buffer read; the
// receiver cannot stall and must take every strobed word. Bytes beyond MAX_LENGTH
// are dropped and overflowed_o is set on every word of that run. row_count_i is
// stored when row_count_we_i is high; the stored value is sampled at the start of
// each run.
module zigzag_row_reorder #(
  parameter int unsigned MAX_LENGTH = zzr_pkg::MAX_LENGTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [zzr_pkg::SYM_W-1:0] symbol_i,
  input  logic                      end_of_message_i,
  input  logic                      row_count_we_i,
  input  logic [zzr_pkg::ROW_W-1:0] row_count_i,
  output logic                      strobe_o,
  output logic [zzr_pkg::SYM_W-1:0] out_symbol_o,
  output logic                      out_last_o,
  output logic                      overflowed_o
);

  localparam int unsigned ADDR_W = $clog2(MAX_LENGTH);

  logic [zzr_pkg::ROW_W-1:0] row_count_q;
  logic                      wr_en;
  logic [ADDR_W-1:0]         wr_addr;
  logic [ADDR_W-1:0]         rd_addr;
  zzr_pkg::rd_ctrl_t         rd;
  zzr_pkg::rd_ctrl_t         out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= zzr_pkg::ROW_W'(1);
      out_q       <= '0;
    end else begin
      if (row_count_we_i) begin
        row_count_q <= row_count_i;
      end
      out_q <= rd;
    end
  end

  zzr_seq #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .end_of_message_i(end_of_message_i),
    .row_count_i     (row_count_q),
    .busy_o          (busy_o),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .rd_o            (rd),
    .rd_addr_o       (rd_addr)
  );

  zzr_mem #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(symbol_i),
    .re_i   (rd.valid),
    .raddr_i(rd_addr),
    .rdata_o(out_symbol_o)
  );

  assign strobe_o     = out_q.valid;
  assign out_last_o   = out_q.last;
  assign overflowed_o = out_q.flag;

endmodule
